FILE: design/octant_line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer modules.
`ifndef OCTANT_LINE_RASTERIZER_MACROS_SVH
`define OCTANT_LINE_RASTERIZER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define OLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Check that cons holds in the cycle after ante.
`define OLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

FILE: design/olr_pkg.sv
// Package with the types, codes and mapping functions of the line rasterizer.
package olr_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef enum logic
    {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } olr_cmd_t;

    typedef enum logic [2:0]
    {
        OCT_0 = 3'd0,
        OCT_1 = 3'd1,
        OCT_2 = 3'd2,
        OCT_3 = 3'd3,
        OCT_4 = 3'd4,
        OCT_5 = 3'd5,
        OCT_6 = 3'd6,
        OCT_7 = 3'd7
    } olr_oct_t;

    // Point in octant-0 coordinates
    typedef struct packed
    {
        logic signed [11:0] u;
        logic signed [11:0] v;
    } olr_uv_t;

    // Point mapped back into its own octant
    typedef struct packed
    {
        logic signed [12:0] x;
        logic signed [12:0] y;
    } olr_xy_t;

    // Classified item handed from front to back
    typedef struct packed
    {
        olr_cmd_t           cmd;
        olr_oct_t           oct;
        logic signed [11:0] u0;
        logic signed [11:0] v0;
        logic signed [11:0] u1;
        logic signed [13:0] dec;
        logic signed [12:0] straight;
        logic signed [13:0] diag;
    } olr_entry_t;

    // Mirror or swap a point of octant oct into octant 0
    function automatic olr_uv_t to_octant0(olr_oct_t oct, logic signed [11:0] x,
                                           logic signed [11:0] y);
        olr_uv_t r;
        unique case (oct)
            OCT_0: begin r.u = x;  r.v = y;  end
            OCT_1: begin r.u = y;  r.v = x;  end
            OCT_2: begin r.u = y;  r.v = -x; end
            OCT_3: begin r.u = -x; r.v = y;  end
            OCT_4: begin r.u = -x; r.v = -y; end
            OCT_5: begin r.u = -y; r.v = -x; end
            OCT_6: begin r.u = -y; r.v = x;  end
            OCT_7: begin r.u = x;  r.v = -y; end
        endcase
        return r;
    endfunction

    // Map an octant-0 point back into octant oct
    function automatic olr_xy_t from_octant0(olr_oct_t oct, logic signed [11:0] u,
                                             logic signed [11:0] v);
        logic signed [12:0] ue;
        logic signed [12:0] ve;
        olr_xy_t r;
        ue = {u[11], u};
        ve = {v[11], v};
        unique case (oct)
            OCT_0: begin r.x = ue;  r.y = ve;  end
            OCT_1: begin r.x = ve;  r.y = ue;  end
            OCT_2: begin r.x = -ve; r.y = ue;  end
            OCT_3: begin r.x = -ue; r.y = ve;  end
            OCT_4: begin r.x = -ue; r.y = -ve; end
            OCT_5: begin r.x = -ve; r.y = -ue; end
            OCT_6: begin r.x = ve;  r.y = -ue; end
            OCT_7: begin r.x = ue;  r.y = -ve; end
        endcase
        return r;
    endfunction

endpackage

FILE: design/octant_line_rasterizer.sv
// Eight-octant midpoint line rasterizer: configuration registers and top-level wiring.
//
// Usage: the input channel (in_valid, in_stall) takes one item per cycle unless
// stalled. A start item (command 0) carries both endpoints and emits the line's first
// pixel; each advance item (command 1) emits the next pixel along the major axis. An
// advance with no line in progress gives no pixel, and a start abandons any line
// in progress. The output channel (out_valid, out_stall) delivers pixel_x and
// pixel_y with the centre offset added, the octant tag and a last flag on the final
// endpoint. An item passes the front stage register and the queue before its pixel
// loads the output register. Throughput: one item per cycle unless stalled; the back
// end steps (decision add, end compare and octant mapping) in one pass.
// The centre is set through cfg_write, cfg_index and cfg_data while no item is
// in flight. Reset clears the centre, the line state, the queue and the output.
// When the receiver stalls the output pixel holds, the back end stops taking
// items, the queue fills and then in_stall rises until space frees up.
module octant_line_rasterizer
#(
    parameter int QUEUE_DEPTH = olr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               command,
    input  logic signed [10:0] x_start,
    input  logic signed [10:0] y_start,
    input  logic signed [10:0] x_end,
    input  logic signed [10:0] y_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [11:0] pixel_x,
    output logic signed [11:0] pixel_y,
    output logic [2:0]         octant,
    output logic               last,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data
);
    import olr_pkg::*;

    logic signed [10:0] center_x_reg;
    logic signed [10:0] center_y_reg;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    olr_entry_t         push_entry;
    olr_entry_t         pop_entry;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= $signed(cfg_data);
                REG_CENTER_Y: center_y_reg <= $signed(cfg_data);
            endcase
        end
    end

    olr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .q_push   (q_push),
        .q_entry  (push_entry),
        .q_full   (q_full)
    );

    olr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .valid     (q_valid)
    );

    olr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .octant    (octant),
        .last      (last)
    );

endmodule

FILE: design/olr_front.sv
// Front end: accepts items, classifies the octant and sets the line terms.
module olr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic signed [10:0]  x_start,
    input  logic signed [10:0]  y_start,
    input  logic signed [10:0]  x_end,
    input  logic signed [10:0]  y_end,
    output logic                q_push,
    output olr_pkg::olr_entry_t q_entry,
    input  logic                q_full
);
    import olr_pkg::*;

    logic               accept;
    logic               a_valid_reg;
    logic               a_valid_next;
    olr_cmd_t           cmd_reg;
    logic signed [10:0] x0_reg;
    logic signed [10:0] y0_reg;
    logic signed [10:0] x1_reg;
    logic signed [10:0] y1_reg;
    logic signed [11:0] dx_reg;
    logic signed [11:0] dy_reg;

    logic [11:0]        ax;
    logic [11:0]        ay;
    logic               x_major;
    logic [11:0]        du;
    logic [11:0]        dv;
    olr_oct_t           oct;
    olr_uv_t            p0;
    olr_uv_t            p1;

    // Hold the item while the queue is full
    assign in_stall = a_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = a_valid_reg && !q_full;

    // Stage valid: load on accept, drop once pushed
    always_comb
    begin
        if (accept)
            a_valid_next = 1'b1;
        else if (q_push)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    // Capture endpoints and their raw differences
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= olr_cmd_t'(command);
            x0_reg  <= x_start;
            y0_reg  <= y_start;
            x1_reg  <= x_end;
            y1_reg  <= y_end;
            dx_reg  <= {x_end[10], x_end} - {x_start[10], x_start};
            dy_reg  <= {y_end[10], y_end} - {y_start[10], y_start};
        end
    end

    // Classify the octant from the signs and magnitudes
    always_comb
    begin
        ax      = dx_reg[11] ? 12'(-dx_reg) : 12'(dx_reg);
        ay      = dy_reg[11] ? 12'(-dy_reg) : 12'(dy_reg);
        x_major = (ax >= ay);
        unique case ({dx_reg[11], dy_reg[11]})
            2'b00: oct = x_major ? OCT_0 : OCT_1;
            2'b10: oct = x_major ? OCT_3 : OCT_2;
            2'b11: oct = x_major ? OCT_4 : OCT_5;
            2'b01: oct = x_major ? OCT_7 : OCT_6;
        endcase
        du = x_major ? ax : ay;
        dv = x_major ? ay : ax;
    end

    // Map the endpoints into octant 0 and set the decision terms
    always_comb
    begin
        p0 = to_octant0(oct, {x0_reg[10], x0_reg}, {y0_reg[10], y0_reg});
        p1 = to_octant0(oct, {x1_reg[10], x1_reg}, {y1_reg[10], y1_reg});
        q_entry.cmd      = cmd_reg;
        q_entry.oct      = oct;
        q_entry.u0       = p0.u;
        q_entry.v0       = p0.v;
        q_entry.u1       = p1.u;
        q_entry.dec      = $signed({1'b0, dv, 1'b0}) - $signed({2'b00, du});
        q_entry.straight = $signed({dv, 1'b0});
        q_entry.diag     = $signed({1'b0, dv, 1'b0}) - $signed({1'b0, du, 1'b0});
    end

endmodule

FILE: design/olr_queue.sv
// Short queue of classified items between the front and back ends.
`include "octant_line_rasterizer_macros.svh"

module olr_queue
#(
    parameter int DEPTH = olr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  olr_pkg::olr_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output olr_pkg::olr_entry_t pop_data,
    output logic                valid
);
    import olr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    olr_entry_t       store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;
    assign pop_data = store_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    `OLR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `OLR_ASSERT_NOW(a_empty_ptrs, clk, rst_n, count_reg == '0, rd_ptr_reg == wr_ptr_reg)
    `OLR_ASSERT_NEXT(a_pop_count, clk, rst_n, do_pop && !do_push,
                     count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: design/olr_back.sv
// Back end: steps the active line and registers one pixel per item, none for an idle advance.
`include "octant_line_rasterizer_macros.svh"

module olr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  olr_pkg::olr_entry_t q_entry,
    output logic                q_pop,
    input  logic signed [10:0]  center_x,
    input  logic signed [10:0]  center_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [11:0]  pixel_x,
    output logic signed [11:0]  pixel_y,
    output logic [2:0]          octant,
    output logic                last
);
    import olr_pkg::*;

    logic signed [11:0] major_pos_reg;
    logic signed [11:0] major_pos_next;
    logic signed [11:0] minor_pos_reg;
    logic signed [11:0] minor_pos_next;
    logic signed [11:0] major_end_reg;
    logic signed [11:0] major_end_next;
    logic signed [13:0] decision_reg;
    logic signed [13:0] decision_next;
    logic signed [12:0] step_straight_reg;
    logic signed [12:0] step_straight_next;
    logic signed [13:0] step_diagonal_reg;
    logic signed [13:0] step_diagonal_next;
    olr_oct_t           line_octant_reg;
    olr_oct_t           line_octant_next;
    logic               line_active_reg;
    logic               line_active_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [11:0] pixel_x_reg;
    logic signed [11:0] pixel_x_next;
    logic signed [11:0] pixel_y_reg;
    logic signed [11:0] pixel_y_next;
    olr_oct_t           octant_reg;
    logic               last_reg;
    logic               last_next;

    logic               out_load;
    olr_xy_t            pix;
    logic signed [12:0] sum_x;
    logic signed [12:0] sum_y;

    // Take the next item whenever the output register is free or draining
    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    // Start loads the line, advance steps it; an idle advance is dropped
    always_comb
    begin
        major_pos_next     = major_pos_reg;
        minor_pos_next     = minor_pos_reg;
        major_end_next     = major_end_reg;
        decision_next      = decision_reg;
        step_straight_next = step_straight_reg;
        step_diagonal_next = step_diagonal_reg;
        line_octant_next   = line_octant_reg;
        line_active_next   = line_active_reg;
        last_next          = 1'b0;
        out_load           = 1'b0;
        if (q_pop)
        begin
            if (q_entry.cmd == CMD_START)
            begin
                major_pos_next     = q_entry.u0;
                minor_pos_next     = q_entry.v0;
                major_end_next     = q_entry.u1;
                decision_next      = q_entry.dec;
                step_straight_next = q_entry.straight;
                step_diagonal_next = q_entry.diag;
                line_octant_next   = q_entry.oct;
                last_next          = (q_entry.u0 >= q_entry.u1);
                line_active_next   = !last_next;
                out_load           = 1'b1;
            end
            else if (line_active_reg)
            begin
                if (!decision_reg[13] && (decision_reg != '0))
                begin
                    minor_pos_next = minor_pos_reg + 1'b1;
                    decision_next  = decision_reg + step_diagonal_reg;
                end
                else
                begin
                    decision_next = decision_reg
                                  + {step_straight_reg[12], step_straight_reg};
                end
                major_pos_next   = major_pos_reg + 1'b1;
                last_next        = (major_pos_next >= major_end_reg);
                line_active_next = !last_next;
                out_load         = 1'b1;
            end
        end
    end

    // Map the new pixel back to its octant and add the centre
    always_comb
    begin
        pix          = from_octant0(line_octant_next, major_pos_next, minor_pos_next);
        sum_x        = pix.x + {{2{center_x[10]}}, center_x};
        sum_y        = pix.y + {{2{center_y[10]}}, center_y};
        pixel_x_next = sum_x[11:0];
        pixel_y_next = sum_y[11:0];
    end

    // Output register: load a pixel, drop it once taken
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg     <= '0;
            minor_pos_reg     <= '0;
            major_end_reg     <= '0;
            decision_reg      <= '0;
            step_straight_reg <= '0;
            step_diagonal_reg <= '0;
            line_octant_reg   <= OCT_0;
            line_active_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            major_pos_reg     <= major_pos_next;
            minor_pos_reg     <= minor_pos_next;
            major_end_reg     <= major_end_next;
            decision_reg      <= decision_next;
            step_straight_reg <= step_straight_next;
            step_diagonal_reg <= step_diagonal_next;
            line_octant_reg   <= line_octant_next;
            line_active_reg   <= line_active_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Hold the pixel payload until a new one loads
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_x_reg <= pixel_x_next;
            pixel_y_reg <= pixel_y_next;
            octant_reg  <= line_octant_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign octant    = octant_reg;
    assign last      = last_reg;

    `OLR_ASSERT_NOW(a_active_before_end, clk, rst_n, line_active_reg,
                    major_pos_reg < major_end_reg)
    `OLR_ASSERT_NEXT(a_last_ends_line, clk, rst_n, out_load && last_next, !line_active_reg)
    `OLR_ASSERT_NOW(a_idle_advance_silent, clk, rst_n,
                    q_pop && (q_entry.cmd == CMD_ADVANCE) && !line_active_reg, !out_load)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the eight-octant line rasterizer.
module testbench;
    import olr_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASES         = 8;
    localparam int PIXELS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS  = 25;

    typedef struct packed
    {
        logic signed [11:0] x;
        logic signed [11:0] y;
        olr_oct_t           oct;
        logic               last;
    } pixel_t;

    typedef enum logic [1:0]
    {
        ROW_PREDICT,
        ROW_NO_PIXEL,
        ROW_PIXEL
    } row_kind_t;

    typedef struct packed
    {
        olr_cmd_t           cmd;
        logic signed [10:0] xs;
        logic signed [10:0] ys;
        logic signed [10:0] xe;
        logic signed [10:0] ye;
        row_kind_t          kind;
        pixel_t             pixel;
    } stim_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               command   = 1'b0;
    logic signed [10:0] x_start   = '0;
    logic signed [10:0] y_start   = '0;
    logic signed [10:0] x_end     = '0;
    logic signed [10:0] y_end     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic [2:0]         octant;
    logic               last;
    logic               cfg_write = 1'b0;
    logic               cfg_index = 1'b0;
    logic [10:0]        cfg_data  = '0;

    // Line tracker: mirrors the block's line state and centre
    logic signed [11:0] ln_major     = '0;
    logic signed [11:0] ln_minor     = '0;
    logic signed [11:0] ln_major_end = '0;
    logic signed [13:0] ln_decision  = '0;
    logic signed [12:0] ln_straight  = '0;
    logic signed [13:0] ln_diagonal  = '0;
    olr_oct_t           ln_oct       = OCT_0;
    bit                 ln_active    = 1'b0;
    logic signed [10:0] centre_x     = '0;
    logic signed [10:0] centre_y     = '0;

    pixel_t    pending_pixels[$];
    pixel_t    head_pixel;
    stim_row_t directed_rows[DIRECTED_ROWS];

    int  errors         = 0;
    int  cycle_count    = 0;
    int  pixels_checked = 0;
    int  last_pixels    = 0;
    int  lines_started  = 0;
    int  pixel_items    = 0;
    int  stall_left     = 0;
    bit  idling         = 1'b0;
    bit  quiet          = 1'b0;
    bit [7:0] octants_seen = '0;

    octant_line_rasterizer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .octant    (octant),
        .last      (last),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Classify a line by the signs and magnitudes of its deltas
    function automatic olr_oct_t octant_of(input int dx, input int dy);
        int adx;
        int ady;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (dy >= 0)
        begin
            if (dx >= 0)
                return (adx >= ady) ? OCT_0 : OCT_1;
            return (adx >= ady) ? OCT_3 : OCT_2;
        end
        if (dx < 0)
            return (adx >= ady) ? OCT_4 : OCT_5;
        return (adx >= ady) ? OCT_7 : OCT_6;
    endfunction

    // Fold a point into octant 0; a is the major axis, b the minor
    function automatic void fold_point(input olr_oct_t oct, input int x, input int y,
                                       output int a, output int b);
        case (oct)
            OCT_0: begin a = x;  b = y;  end
            OCT_1: begin a = y;  b = x;  end
            OCT_2: begin a = y;  b = -x; end
            OCT_3: begin a = -x; b = y;  end
            OCT_4: begin a = -x; b = -y; end
            OCT_5: begin a = -y; b = -x; end
            OCT_6: begin a = -y; b = x;  end
            default: begin a = x; b = -y; end
        endcase
    endfunction

    // Unfold an octant-0 point back into its own octant
    function automatic void unfold_point(input olr_oct_t oct, input int a, input int b,
                                         output int x, output int y);
        case (oct)
            OCT_0: begin x = a;  y = b;  end
            OCT_1: begin x = b;  y = a;  end
            OCT_2: begin x = -b; y = a;  end
            OCT_3: begin x = -a; y = b;  end
            OCT_4: begin x = -a; y = -b; end
            OCT_5: begin x = -b; y = -a; end
            OCT_6: begin x = b;  y = -a; end
            default: begin x = a; y = -b; end
        endcase
    endfunction

    // Step the line tracker for one item and form the pixel it yields
    task automatic trace_line_item(input olr_cmd_t cmd, input int xs, input int ys,
                                   input int xe, input int ye,
                                   output bit has_pixel, output pixel_t px);
        int a0;
        int b0;
        int a1;
        int b1;
        int ox;
        int oy;
        bit at_end;
        has_pixel = 1'b0;
        at_end    = 1'b0;
        px        = '0;
        if (cmd == CMD_START)
        begin
            ln_oct = octant_of(xe - xs, ye - ys);
            fold_point(ln_oct, xs, ys, a0, b0);
            fold_point(ln_oct, xe, ye, a1, b1);
            ln_major     = 12'(a0);
            ln_minor     = 12'(b0);
            ln_major_end = 12'(a1);
            ln_decision  = 14'(2 * (b1 - b0) - (a1 - a0));
            ln_straight  = 13'(2 * (b1 - b0));
            ln_diagonal  = 14'(2 * ((b1 - b0) - (a1 - a0)));
            at_end       = (a0 >= a1);
            ln_active    = !at_end;
            has_pixel    = 1'b1;
        end
        else if (ln_active)
        begin
            if (ln_decision > 0)
            begin
                ln_minor    = 12'(ln_minor + 1);
                ln_decision = ln_decision + ln_diagonal;
            end
            else
                ln_decision = ln_decision + 14'(ln_straight);
            ln_major = 12'(ln_major + 1);
            at_end   = (ln_major >= ln_major_end);
            if (at_end)
                ln_active = 1'b0;
            has_pixel = 1'b1;
        end
        if (has_pixel)
        begin
            unfold_point(ln_oct, int'(ln_major), int'(ln_minor), ox, oy);
            px.x    = 12'(ox + centre_x);
            px.y    = 12'(oy + centre_y);
            px.oct  = ln_oct;
            px.last = at_end;
        end
    endtask

    function automatic stim_row_t stim_row(input olr_cmd_t cmd, input int xs, input int ys,
                                           input int xe, input int ye, input row_kind_t kind,
                                           input int px, input int py, input olr_oct_t oct,
                                           input bit lst);
        stim_row_t r;
        r.cmd        = cmd;
        r.xs         = 11'(xs);
        r.ys         = 11'(ys);
        r.xe         = 11'(xe);
        r.ye         = 11'(ye);
        r.kind       = kind;
        r.pixel.x    = 12'(px);
        r.pixel.y    = 12'(py);
        r.pixel.oct  = oct;
        r.pixel.last = lst;
        return r;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0: return -1024;
            1: return 1023;
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    function automatic int near_coord(input int base);
        int v;
        v = base + int'($urandom_range(0, 24)) - 12;
        if (v < -1024)
            return -1024;
        if (v > 1023)
            return 1023;
        return v;
    endfunction

    // Offer one item, hold it until taken, then update the tracker
    task automatic send_item(input olr_cmd_t cmd, input int xs, input int ys,
                             input int xe, input int ye,
                             output bit has_pixel, output pixel_t px);
        int gap;
        gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command  <= cmd;
        x_start  <= 11'(xs);
        y_start  <= 11'(ys);
        x_end    <= 11'(xe);
        y_end    <= 11'(ye);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        trace_line_item(cmd, xs, ys, xe, ye, has_pixel, px);
        if (cmd == CMD_START)
            lines_started++;
        @(negedge clk);
    endtask

    task automatic queue_pixel(input bit has_pixel, input pixel_t px);
        if (has_pixel)
        begin
            pending_pixels.push_back(px);
            pixel_items++;
        end
    endtask

    // One random burst: mostly a start followed by a full walk or a cut-short one, else a lone advance
    task automatic send_random_burst();
        int     kind;
        int     xs;
        int     ys;
        int     xe;
        int     ye;
        int     steps;
        int     remaining;
        bit     has_pixel;
        pixel_t px;
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            send_item(CMD_ADVANCE, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      has_pixel, px);
            queue_pixel(has_pixel, px);
        end
        else
        begin
            xs = pick_coord();
            ys = pick_coord();
            if (kind < 5)
            begin
                xe = pick_coord();
                ye = pick_coord();
            end
            else
            begin
                xe = near_coord(xs);
                ye = near_coord(ys);
            end
            send_item(CMD_START, xs, ys, xe, ye, has_pixel, px);
            queue_pixel(has_pixel, px);
            remaining = ln_active ? (int'(ln_major_end) - int'(ln_major)) : 0;
            if (remaining > 30 || $urandom_range(0, 3) == 0)
                steps = $urandom_range(0, (remaining > 30) ? 30 : remaining);
            else
                steps = remaining + $urandom_range(0, 2);
            repeat (steps)
            begin
                send_item(CMD_ADVANCE, pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), has_pixel, px);
                queue_pixel(has_pixel, px);
            end
        end
    endtask

    // Drop valid, free the output and wait for every pixel, then let the pipe empty
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        quiet = 1'b1;
        @(negedge clk);
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_centre(input int cx, input int cy);
        cfg_write <= 1'b1;
        cfg_index <= REG_CENTER_X;
        cfg_data  <= 11'(cx);
        @(negedge clk);
        cfg_index <= REG_CENTER_Y;
        cfg_data  <= 11'(cy);
        @(negedge clk);
        cfg_write <= 1'b0;
        centre_x = 11'(cx);
        centre_y = 11'(cy);
    endtask

    // Receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (!rst_n || !idling || quiet)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each pixel taken with the oldest one waiting
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel with none pending: x %0d y %0d octant %0d last %0d",
                       pixel_x, pixel_y, octant, last);
                errors++;
            end
            else
            begin
                head_pixel = pending_pixels.pop_front();
                if (pixel_x !== head_pixel.x)
                begin
                    $error("pixel_x: expected %0d, got %0d", head_pixel.x, pixel_x);
                    errors++;
                end
                if (pixel_y !== head_pixel.y)
                begin
                    $error("pixel_y: expected %0d, got %0d", head_pixel.y, pixel_y);
                    errors++;
                end
                if (octant !== head_pixel.oct)
                begin
                    $error("octant: expected %0d, got %0d", head_pixel.oct, octant);
                    errors++;
                end
                if (last !== head_pixel.last)
                begin
                    $error("last: expected %0d, got %0d", head_pixel.last, last);
                    errors++;
                end
                octants_seen[head_pixel.oct] = 1'b1;
                if (head_pixel.last)
                    last_pixels++;
                pixels_checked++;
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL octant_line_rasterizer");
            $finish;
        end
    end

    initial
    begin
        bit     has_pixel;
        pixel_t px;
        int     cx;
        int     cy;

        // Directed lines: extremes, every octant, single points and idle advances
        directed_rows = '{
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 0, 0, 0, 0, ROW_PIXEL, 0, 0, OCT_0, 1),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, OCT_0, 0),
            stim_row(CMD_START, -1024, -1024, 1023, 1023, ROW_PIXEL, -1024, -1024, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 1023, -1024, -1024, 1023, ROW_PIXEL, 1023, -1024, OCT_3, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, -1024, 1023, -1024, -1024, ROW_PIXEL, -1024, 1023, OCT_6, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 1023, 1023, -1024, -1024, ROW_PIXEL, 1023, 1023, OCT_4, 0),
            stim_row(CMD_START, 0, 0, 3, 1, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_NO_PIXEL, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 0, 0, 1, 3, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 0, 0, -1, 3, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 5, 5, 2, 3, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 0, 0, -1, -3, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 0, 0, 2, -5, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, -2, 4, 3, 2, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_ADVANCE, 0, 0, 0, 0, ROW_PREDICT, 0, 0, OCT_0, 0),
            stim_row(CMD_START, 7, -3, 7, -3, ROW_PIXEL, 7, -3, OCT_0, 1)
        };

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idling = 1'b1;

        // Walk the directed table with the reset centre
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_item(directed_rows[i].cmd, directed_rows[i].xs, directed_rows[i].ys,
                      directed_rows[i].xe, directed_rows[i].ye, has_pixel, px);
            case (directed_rows[i].kind)
                ROW_PREDICT: queue_pixel(has_pixel, px);
                ROW_PIXEL:   queue_pixel(1'b1, directed_rows[i].pixel);
                default:     ;
            endcase
        end

        // Random lines under a series of centre settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_pipeline();
            case (ph)
                0: begin cx = 1023;  cy = -1024; end
                1: begin cx = -1024; cy = 1023;  end
                2: begin cx = -1024; cy = -1024; end
                3: begin cx = 1023;  cy = 1023;  end
                5: begin cx = -1023; cy = 1023;  end
                7: begin cx = 0;     cy = 0;     end
                default:
                begin
                    cx = pick_coord();
                    cy = pick_coord();
                end
            endcase
            write_centre(cx, cy);
            idling = (ph != 3 && ph != PHASES - 1);
            quiet  = 1'b0;
            pixel_items = 0;
            while (pixel_items < PIXELS_PER_PHASE)
                send_random_burst();
        end

        settle_pipeline();
        $display("Checked %0d pixels from %0d lines, %0d of them line ends.",
                 pixels_checked, lines_started, last_pixels);
        $display("Pixels fell in %0d octants over %0d centre settings.",
                 $countones(octants_seen), PHASES + 1);
        if (errors == 0)
            $display("PASS octant_line_rasterizer");
        else
            $display("FAIL octant_line_rasterizer");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/olr_pkg.sv
design/olr_front.sv
design/olr_queue.sv
design/olr_back.sv
design/octant_line_rasterizer.sv
tb/testbench.sv
